// ===== rtl/blocked_id_fifo_with_search_unit_macros.svh =====
// Assertion macros shared by the blocked-id queue modules.
`ifndef BLOCKED_ID_FIFO_WITH_SEARCH_UNIT_MACROS_SVH
`define BLOCKED_ID_FIFO_WITH_SEARCH_UNIT_MACROS_SVH

// Invariant that holds at every clock edge out of reset.
`define BIFS_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("bifs invariant violated");

// Condition implies consequence in the same cycle.
`define BIFS_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bifs implication violated");

// Condition implies consequence in the next cycle.
`define BIFS_IMPLY_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bifs sequence violated");

`endif

// ===== rtl/bifs_pkg.sv =====
// Shared constants, types and helpers for the blocked-id queue.
`default_nettype none

package bifs_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_BITS = 16;
  localparam int ID_W    = 16;
  localparam int STORE_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ   = 2'd0,
    OP_DEQ   = 2'd1,
    OP_QRY   = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  localparam logic KIND_UNBLOCK = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic load_unblock;
    logic scan_step;
    logic load_query;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic rem_zero;
    logic scan_done;
  } dp_status_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bifs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bifs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/bifs_dp.sv =====
// Queue datapath: pointers, count, entry RAM, search compare and result register.
`default_nettype none
`include "blocked_id_fifo_with_search_unit_macros.svh"

module bifs_dp
  import bifs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dp_cmd_t          cmd,
  input  wire logic [1:0]       in_op,
  input  wire logic [ID_W-1:0]  in_proc_id,
  output dp_status_t            status,
  output logic                  out_kind,
  output logic      [ID_W-1:0]  out_id,
  output logic                  out_found,
  output logic                  out_last
);

  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               hit_r, hit_nxt;
  logic [STORE_W-1:0] key_r, key_nxt;
  logic               kind_r;
  logic [ID_W-1:0]    id_r;
  logic               found_r;
  logic               last_r;

  logic               full;
  logic               mem_we;
  logic               mem_re;
  logic [STORE_W-1:0] in_key;
  logic [STORE_W-1:0] mem_rdata;
  op_t                op;

  assign op     = op_t'(in_op);
  assign in_key = in_proc_id[STORE_W-1:0];
  assign full   = (count_r == CNT_W'(DEPTH));
  assign mem_we = cmd.accept && (op == OP_ENQ) && !full;
  assign mem_re = cmd.rd_issue || (cmd.scan_step && (rem_r != '0));

  bifs_ram #(
    .WIDTH(STORE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(tail_r),
    .wdata(in_key),
    .re   (mem_re),
    .raddr(scan_ptr_r),
    .rdata(mem_rdata)
  );

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    scan_ptr_nxt = scan_ptr_r;
    rem_nxt      = rem_r;
    cmp_vld_nxt  = cmp_vld_r;
    hit_nxt      = hit_r;
    key_nxt      = key_r;

    if (cmd.accept) begin
      unique case (op)
        OP_ENQ: begin
          if (!full) begin
            tail_nxt  = next_slot(tail_r);
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEQ: begin
          if (count_r != '0) begin
            scan_ptr_nxt = head_r;
            rem_nxt      = CNT_W'(1);
            head_nxt     = next_slot(head_r);
            count_nxt    = count_r - 1'b1;
          end
        end
        OP_QRY: begin
          scan_ptr_nxt = head_r;
          rem_nxt      = count_r;
          key_nxt      = in_key;
          hit_nxt      = 1'b0;
          cmp_vld_nxt  = 1'b0;
        end
        OP_FLUSH: begin
          // Entries stay in the RAM; the drain walks them from the old head.
          scan_ptr_nxt = head_r;
          rem_nxt      = count_r;
          head_nxt     = '0;
          tail_nxt     = '0;
          count_nxt    = '0;
        end
        default: ;
      endcase
    end

    if (mem_re) begin
      scan_ptr_nxt = next_slot(scan_ptr_r);
      rem_nxt      = rem_r - 1'b1;
    end

    if (cmd.scan_step) begin
      cmp_vld_nxt = (rem_r != '0);
      if (cmp_vld_r && (mem_rdata == key_r)) begin
        hit_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      rem_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      rem_r     <= rem_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_ptr_r <= scan_ptr_nxt;
    hit_r      <= hit_nxt;
    key_r      <= key_nxt;
    if (cmd.load_unblock) begin
      kind_r  <= KIND_UNBLOCK;
      id_r    <= ID_W'(mem_rdata);
      found_r <= 1'b0;
      last_r  <= (rem_r == '0);
    end else if (cmd.load_query) begin
      kind_r  <= KIND_QUERY;
      id_r    <= ID_W'(key_r);
      found_r <= hit_r;
      last_r  <= 1'b1;
    end
  end

  assign status.empty     = (count_r == '0);
  assign status.rem_zero  = (rem_r == '0);
  assign status.scan_done = (rem_r == '0) && !cmp_vld_r;

  assign out_kind  = kind_r;
  assign out_id    = id_r;
  assign out_found = found_r;
  assign out_last  = last_r;

  `BIFS_CHECK(a_count_bound, count_r <= CNT_W'(DEPTH))
  `BIFS_CHECK(a_ptr_meet, ((count_r == '0) || full) == (head_r == tail_r))

endmodule

`default_nettype wire

// ===== rtl/bifs_ctrl.sv =====
// Queue controller: sequences accepts, RAM reads, searches and result hand-off.
`default_nettype none
`include "blocked_id_fifo_with_search_unit_macros.svh"

module bifs_ctrl
  import bifs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_SCAN,
    ST_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, out_valid_r;
  logic   in_ready_nxt, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept = 1'b1;
          unique case (op_t'(in_op))
            OP_ENQ:   state_nxt = ST_IDLE;
            OP_DEQ:   state_nxt = status.empty ? ST_IDLE : ST_RD;
            OP_QRY:   state_nxt = ST_SCAN;
            OP_FLUSH: state_nxt = status.empty ? ST_IDLE : ST_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_LD;
      end
      ST_LD: begin
        cmd.load_unblock = 1'b1;
        state_nxt        = ST_HOLD;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          cmd.load_query = 1'b1;
          state_nxt      = ST_HOLD;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_ready) begin
          state_nxt = status.rem_zero ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    in_ready_nxt  = (state_nxt == ST_IDLE);
    out_valid_nxt = (state_nxt == ST_HOLD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  `BIFS_IMPLY(a_one_side, out_valid_r, !in_ready_r)
  `BIFS_IMPLY_NEXT(a_query_shown, cmd.load_query, out_valid_r)

endmodule

`default_nettype wire

// ===== rtl/blocked_id_fifo_with_search_unit.sv =====
// Top level of the blocked-id queue with membership search.
//
// Input channel (in_valid/in_ready, in_op, in_proc_id) carries one operation per
// transaction: enqueue, dequeue oldest, membership query or flush all.
// Result channel (out_valid/out_ready, out_kind, out_id, out_found, out_last)
// carries unblock results and query answers; out_last marks the final result
// of the operation that caused it.
// The block works on one operation at a time; in_ready is low while it is busy.
// Enqueue: no result; a full queue drops the identifier.
// Dequeue: the entry is read in ST_RD, loaded in ST_LD and shown in ST_HOLD; an
// empty queue gives none. Query: ST_SCAN reads one entry per cycle through the
// single RAM read port, then the last compare drains and the answer is shown.
// Flush: each held entry is read, loaded and shown in turn, oldest first;
// the pointers clear at the accept, the drain then walks the stored entries.
// When the receiver stalls, the result register holds its transaction and the
// sequence waits; input is refused until the last result is taken.
// Synchronous active-low reset empties the queue; in_ready rises in the cycle
// after reset releases. The entry RAM itself is not cleared.
`default_nettype none

module blocked_id_fifo_with_search_unit
  import bifs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_op,
  input  wire logic [ID_W-1:0] in_proc_id,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_kind,
  output logic      [ID_W-1:0] out_id,
  output logic                 out_found,
  output logic                 out_last
);

  // Commands from the controller, status back from the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence accepts, drain reads, search steps and result hand-off.
  bifs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the queue state, the entry RAM and the result register.
  bifs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_op     (in_op),
    .in_proc_id(in_proc_id),
    .status    (status),
    .out_kind  (out_kind),
    .out_id    (out_id),
    .out_found (out_found),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire
